// ===== sv/timer_deadline_queue_unit_assert.svh =====
// Assertion macros for the timer deadline queue unit.
// Included by the checker module; depends on nothing else.
`ifndef TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH
`define TIMER_DEADLINE_QUEUE_UNIT_ASSERT_SVH

// Checked only while reset is released.
`define TDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tdq_pkg.sv =====
// Shared types and constants of the timer deadline queue unit.
// Used by the queue cells, the cell chain, the top level and the checker.
`default_nettype none

package tdq_pkg;

    localparam int TDQ_DEPTH = 32;

    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] KIND_TIMEOUT      = 3'd0;
    localparam logic [2:0] KIND_END_NOSWITCH = 3'd1;
    localparam logic [2:0] KIND_END_SWITCH   = 3'd2;
    localparam logic [2:0] KIND_ADDED        = 3'd3;
    localparam logic [2:0] KIND_FULL         = 3'd4;

    localparam logic CFG_TASK_VALUE  = 1'b0;
    localparam logic CFG_TASK_PERIOD = 1'b1;

    localparam logic [31:0] TASK_VALUE_RESET  = 32'h7FFF_FFFF;
    localparam logic [15:0] TASK_PERIOD_RESET = 16'd2;

    typedef struct packed {
        logic        valid;
        logic [31:0] deadline;
        logic [31:0] value;
    } t_entry;

    typedef struct packed {
        logic        ins;
        logic        pop;
        logic [31:0] deadline;
        logic [31:0] value;
    } t_chain_cmd;

endpackage

`default_nettype wire

// ===== sv/tdq_cell.sv =====
// One cell of the sorted timer chain: holds a single timer entry.
// Depends on tdq_pkg for the entry and command types.
`default_nettype none

module tdq_cell
    import tdq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_chain_cmd i_cmd,
    input  t_entry     i_prev,
    input  wire        i_prev_le,
    input  t_entry     i_next,
    output t_entry     o_entry,
    output logic       o_le
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_entry = r_entry;
    assign o_le    = r_entry.valid && (r_entry.deadline <= i_cmd.deadline);

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.pop) begin
            n_entry = i_next;
        end else if (i_cmd.ins && !o_le) begin
            if (i_prev_le) begin
                n_entry.valid    = 1'b1;
                n_entry.deadline = i_cmd.deadline;
                n_entry.value    = i_cmd.value;
            end else begin
                n_entry = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.deadline <= n_entry.deadline;
        r_entry.value    <= n_entry.value;
    end

endmodule

`default_nettype wire

// ===== sv/tdq_chain.sv =====
// Row of timer cells kept sorted by deadline, head in the first cell.
// Depends on tdq_pkg and tdq_cell.
`default_nettype none

module tdq_chain
    import tdq_pkg::*;
#(
    parameter int DEPTH = TDQ_DEPTH
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_chain_cmd i_cmd,
    output t_entry     o_head,
    output logic       o_full
);

    t_entry w_entry [DEPTH];
    logic   w_le    [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_le;

        if (g == 0) begin : g_first
            assign w_prev    = '0;
            assign w_prev_le = 1'b1;
        end else begin : g_mid
            assign w_prev    = w_entry[g-1];
            assign w_prev_le = w_le[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end

        tdq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (i_cmd),
            .i_prev    (w_prev),
            .i_prev_le (w_prev_le),
            .i_next    (w_next),
            .o_entry   (w_entry[g]),
            .o_le      (w_le[g])
        );
    end

    assign o_head = w_entry[0];
    assign o_full = w_entry[DEPTH-1].valid;

endmodule

`default_nettype wire

// ===== sv/timer_deadline_queue_unit.sv =====
// An add goes from S_IDLE to S_END, which loads its single result word. A tick goes to S_SCAN,
// which loads one word per expired timer and stops at a re-arm, passing S_REARM, then to S_END.
// S_END loads the final word, and the next item is accepted once the sequencer is back in S_IDLE.
// A stalled output holds the sequencer in S_SCAN and S_END.
// Synchronous active-low reset empties the queue, clears the counter and restores the task timer.
`default_nettype none

module timer_deadline_queue_unit
    import tdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = TDQ_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  wire               i_action,
    input  wire        [31:0] i_new_deadline,
    input  wire signed [31:0] i_new_value,
    output logic              o_valid,
    input  wire               i_stall,
    output logic       [2:0]  o_kind,
    output logic       [31:0] o_expired_deadline,
    output logic signed [31:0] o_expired_value,
    output logic              o_last,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire               i_cfg_index,
    input  wire        [31:0] i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_REARM = 4'b0100,
        S_END   = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [31:0] r_tick, n_tick;
    logic [2:0]  r_end_kind, n_end_kind;
    logic [31:0] r_rearm_dl, n_rearm_dl;
    logic [31:0] r_task_value;
    logic [15:0] r_task_period;

    logic        r_out_valid;
    logic [2:0]  r_kind;
    logic [31:0] r_dl;
    logic [31:0] r_val;
    logic        r_last;

    t_chain_cmd  w_cmd;
    t_entry      w_head;
    logic        w_full;
    logic        w_out_free;
    logic        w_load;
    logic [2:0]  w_kind;
    logic [31:0] w_dl;
    logic [31:0] w_val;
    logic        w_last;
    logic [32:0] w_rearm_sum;
    logic        w_due;

    tdq_chain #(
        .DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_head  (w_head),
        .o_full  (w_full)
    );

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_rearm_sum = {1'b0, r_tick} + {17'd0, r_task_period};
    assign w_due       = w_head.valid && (w_head.deadline <= r_tick);

    always_comb begin
        n_state    = r_state;
        n_tick     = r_tick;
        n_end_kind = r_end_kind;
        n_rearm_dl = r_rearm_dl;
        w_cmd      = '0;
        w_load     = 1'b0;
        w_kind     = KIND_TIMEOUT;
        w_dl       = '0;
        w_val      = '0;
        w_last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action) begin
                        if (w_full) begin
                            n_end_kind = KIND_FULL;
                        end else begin
                            w_cmd.ins      = 1'b1;
                            w_cmd.deadline = i_new_deadline;
                            w_cmd.value    = i_new_value;
                            n_end_kind     = KIND_ADDED;
                        end
                        n_state = S_END;
                    end else begin
                        if (r_tick != TICK_MAX) begin
                            n_tick = r_tick + 32'd1;
                        end
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_due) begin
                    if (w_head.value == r_task_value) begin
                        w_cmd.pop  = 1'b1;
                        n_rearm_dl = w_rearm_sum[32] ? TICK_MAX : w_rearm_sum[31:0];
                        n_state    = S_REARM;
                    end else if (w_out_free) begin
                        w_cmd.pop = 1'b1;
                        w_load    = 1'b1;
                        w_kind    = KIND_TIMEOUT;
                        w_dl      = w_head.deadline;
                        w_val     = w_head.value;
                    end
                end else begin
                    n_end_kind = KIND_END_NOSWITCH;
                    n_state    = S_END;
                end
            end
            S_REARM: begin
                w_cmd.ins      = 1'b1;
                w_cmd.deadline = r_rearm_dl;
                w_cmd.value    = r_task_value;
                n_end_kind     = KIND_END_SWITCH;
                n_state        = S_END;
            end
            S_END: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    w_kind  = r_end_kind;
                    w_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_tick        <= '0;
            r_out_valid   <= 1'b0;
            r_task_value  <= TASK_VALUE_RESET;
            r_task_period <= TASK_PERIOD_RESET;
        end else begin
            r_state <= n_state;
            r_tick  <= n_tick;
            if (w_out_free) begin
                r_out_valid <= w_load;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TASK_VALUE:  r_task_value  <= i_cfg_data;
                    CFG_TASK_PERIOD: r_task_period <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
        r_end_kind <= n_end_kind;
        r_rearm_dl <= n_rearm_dl;
        if (w_load) begin
            r_kind <= w_kind;
            r_dl   <= w_dl;
            r_val  <= w_val;
            r_last <= w_last;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_kind             = r_kind;
    assign o_expired_deadline = r_dl;
    assign o_expired_value    = r_val;
    assign o_last             = r_last;

endmodule

`default_nettype wire

// ===== sv/tdq_checker.sv =====
// Port-level checker for the timer deadline queue unit, bound to the top level.
// Depends on tdq_pkg and the assertion macro header.
`default_nettype none

`include "timer_deadline_queue_unit_assert.svh"

module tdq_checker
    import tdq_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_stall,
    input wire               i_action,
    input wire        [31:0] i_new_deadline,
    input wire signed [31:0] i_new_value,
    input wire               o_valid,
    input wire               i_stall,
    input wire        [2:0]  o_kind,
    input wire        [31:0] o_expired_deadline,
    input wire signed [31:0] o_expired_value,
    input wire               o_last,
    input wire               i_cfg_valid,
    input wire               o_cfg_ready,
    input wire               i_cfg_index,
    input wire        [31:0] i_cfg_data
);

    `TDQ_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid, "output word after reset")

    `TDQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall, "second word accepted while busy")

    `TDQ_ASSERT(a_last_matches_kind, i_clk, i_rst_n, o_valid |-> (o_last == (o_kind != KIND_TIMEOUT)), "last flag disagrees with kind")

    `TDQ_ASSERT(a_zero_payload, i_clk, i_rst_n, (o_valid && o_kind != KIND_TIMEOUT) |-> (o_expired_deadline == 32'd0 && o_expired_value == 32'sd0), "nonzero payload on a final word")

    `TDQ_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_expired_deadline)), "stalled output word changed")

endmodule

bind timer_deadline_queue_unit tdq_checker u_tdq_checker (.*);

`default_nettype wire

// ===== bench/tb_timer_deadline_queue_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for timer_deadline_queue_unit: directed and random add and tick words,
// each predicted by a timer queue model kept in the bench and checked word by word on the output.
// Depends on tdq_pkg and the timer_deadline_queue_unit RTL.

module tb_timer_deadline_queue_unit;
    import tdq_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] deadline;
        logic [31:0] value;
        logic        last;
    } t_word;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               i_action;
    logic        [31:0] i_new_deadline;
    logic signed [31:0] i_new_value;
    logic               o_valid;
    logic               i_stall;
    logic        [2:0]  o_kind;
    logic        [31:0] o_expired_deadline;
    logic signed [31:0] o_expired_value;
    logic               o_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic        [31:0] i_cfg_data;

    timer_deadline_queue_unit i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (i_action),
        .i_new_deadline     (i_new_deadline),
        .i_new_value        (i_new_value),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_kind             (o_kind),
        .o_expired_deadline (o_expired_deadline),
        .o_expired_value    (o_expired_value),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Timer queue model state.
    logic [31:0] model_tick;
    logic [31:0] model_deadline [TDQ_DEPTH];
    logic [31:0] model_value [TDQ_DEPTH];
    int          model_count;
    logic [31:0] model_task_value;
    logic [15:0] model_task_period;

    t_word       expected_words[$];
    t_word       got_word;
    t_word       want_word;
    int          err_count;
    int          burst_left;
    int          far_deadlines_left;

    int          stall_cycle;
    int          stall_mode;
    int          stall_hold;
    logic [7:0]  stall_pattern;
    logic        stall_next;

    always #2 i_clk = ~i_clk;

    function automatic void queue_insert_timer(logic [31:0] dl, logic [31:0] val);
        int pos;
        pos = model_count;
        while (pos > 0 && model_deadline[pos - 1] > dl) begin
            model_deadline[pos] = model_deadline[pos - 1];
            model_value[pos] = model_value[pos - 1];
            pos--;
        end
        model_deadline[pos] = dl;
        model_value[pos] = val;
        model_count++;
    endfunction

    function automatic void queue_drop_head();
        for (int i = 1; i < model_count; i++) begin
            model_deadline[i - 1] = model_deadline[i];
            model_value[i - 1] = model_value[i];
        end
        model_count--;
    endfunction

    function automatic void push_word(logic [2:0] kind, logic [31:0] dl, logic [31:0] val,
                                      logic last);
        t_word w;
        w.kind = kind;
        w.deadline = dl;
        w.value = val;
        w.last = last;
        expected_words.push_back(w);
    endfunction

    function automatic void predict_timer_words(logic action, logic [31:0] dl,
                                                logic [31:0] val);
        logic        switched;
        logic [31:0] head_dl;
        logic [31:0] head_val;
        logic [32:0] rearm_sum;
        logic [31:0] rearm_dl;
        if (action == ACT_ADD) begin
            if (model_count >= TDQ_DEPTH) begin
                push_word(KIND_FULL, 32'd0, 32'd0, 1'b1);
            end else begin
                queue_insert_timer(dl, val);
                push_word(KIND_ADDED, 32'd0, 32'd0, 1'b1);
            end
            return;
        end
        if (model_tick != TICK_MAX) model_tick = model_tick + 32'd1;
        switched = 1'b0;
        while (!switched && model_count > 0 && model_deadline[0] <= model_tick) begin
            head_dl = model_deadline[0];
            head_val = model_value[0];
            if (head_val == model_task_value) begin
                rearm_sum = {1'b0, model_tick} + {17'd0, model_task_period};
                rearm_dl = rearm_sum[32] ? TICK_MAX : rearm_sum[31:0];
                queue_drop_head();
                queue_insert_timer(rearm_dl, head_val);
                switched = 1'b1;
            end else begin
                push_word(KIND_TIMEOUT, head_dl, head_val, 1'b0);
                queue_drop_head();
            end
        end
        push_word(switched ? KIND_END_SWITCH : KIND_END_NOSWITCH, 32'd0, 32'd0, 1'b1);
    endfunction

    task automatic send_item(input logic action, input logic [31:0] dl, input logic [31:0] val);
        int gap;
        gap = 0;
        i_action = action;
        i_new_deadline = dl;
        i_new_value = val;
        i_valid = 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_timer_words(action, dl, val);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_item(ACT_TICK, $urandom, $urandom);
    endtask

    task automatic wait_drained();
        if (i_valid) i_valid = 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TASK_VALUE) model_task_value = data;
        else model_task_period = data[15:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_task_timer(input logic [31:0] value, input logic [15:0] period);
        wait_drained();
        write_reg(CFG_TASK_VALUE, value);
        write_reg(CFG_TASK_PERIOD, {16'd0, period});
    endtask

    task automatic test_empty_tick();
        send_tick();
    endtask

    task automatic test_order_and_ties();
        logic [31:0] base;
        base = model_tick;
        send_item(ACT_ADD, base + 32'd2, 32'h8000_0000);
        send_item(ACT_ADD, base + 32'd1, 32'h7FFF_FFFE);
        send_item(ACT_ADD, base + 32'd2, 32'h0000_0000);
        send_item(ACT_ADD, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(ACT_ADD, TICK_MAX, 32'h1234_5678);
        send_item(ACT_ADD, base + 32'd1, 32'h0000_0001);
        repeat (3) send_tick();
    endtask

    task automatic test_full_queue();
        while (model_count < TDQ_DEPTH)
            send_item(ACT_ADD, model_tick + 32'd1 + $urandom_range(0, 1), $urandom);
        send_item(ACT_ADD, $urandom, $urandom);
        repeat (3) send_tick();
    endtask

    task automatic test_default_task_timer();
        send_item(ACT_ADD, model_tick + 32'd1, TASK_VALUE_RESET);
        send_item(ACT_ADD, model_tick + 32'd1, $urandom);
        repeat (3) send_tick();
    endtask

    task automatic test_zero_and_long_period();
        logic [31:0] marker;
        marker = $urandom;
        set_task_timer(marker, 16'd0);
        send_item(ACT_ADD, model_tick + 32'd1, marker);
        send_item(ACT_ADD, model_tick + 32'd2, $urandom);
        repeat (3) send_tick();
        set_task_timer(marker, 16'hFFFF);
        repeat (2) send_tick();
    endtask

    task automatic test_random_traffic(input int n_items);
        int          pick;
        logic [31:0] dl;
        logic [31:0] val;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < ((model_count < 24) ? 50 : 20)) begin
                pick = $urandom_range(0, 9);
                if (pick == 0 && far_deadlines_left > 0) begin
                    far_deadlines_left--;
                    dl = $urandom;
                end else if (pick == 1) begin
                    dl = (model_tick > 32'd3) ? model_tick - $urandom_range(0, 3) : 32'd0;
                end else begin
                    dl = model_tick + $urandom_range(0, 6);
                end
                pick = $urandom_range(0, 7);
                if (pick == 0) val = model_task_value;
                else if (pick == 1) val = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{pick[0]}}};
                else val = $urandom;
                send_item(ACT_ADD, dl, val);
            end else begin
                send_tick();
            end
        end
    endtask

    always @(negedge i_clk) begin
        stall_cycle++;
        if (stall_cycle % 64 == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_pattern = 8'($urandom);
        end
        case (stall_mode)
            0: begin
                stall_next = 1'b0;
            end
            1: begin
                stall_next = 1'($urandom_range(0, 1));
            end
            2: begin
                stall_next = stall_pattern[stall_cycle % 8];
            end
            default: begin
                if (stall_hold > 0) begin
                    stall_hold--;
                    stall_next = 1'b1;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_hold = $urandom_range(4, 24);
                    stall_next = 1'b1;
                end else begin
                    stall_next = 1'b0;
                end
            end
        endcase
        i_stall = stall_next;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got_word = {o_kind, o_expired_deadline, o_expired_value, o_last};
            if (expected_words.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("unexpected word: kind %0d deadline %h value %h last %0d",
                             got_word.kind, got_word.deadline, got_word.value, got_word.last);
                err_count++;
            end else begin
                want_word = expected_words.pop_front();
                if (got_word !== want_word) begin
                    if (err_count < MAX_REPORTS)
                        $display("word mismatch: kind %0d/%0d deadline %h/%h ",
                                 want_word.kind, got_word.kind,
                                 want_word.deadline, got_word.deadline,
                                 "value %h/%h last %0d/%0d (expected/actual)",
                                 want_word.value, got_word.value,
                                 want_word.last, got_word.last);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("tb_timer_deadline_queue_unit: done, errors");
        $finish;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_TICK;
        i_new_deadline = 32'd0;
        i_new_value = 32'sd0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TASK_VALUE;
        i_cfg_data = 32'd0;
        model_tick = 32'd0;
        model_count = 0;
        model_task_value = TASK_VALUE_RESET;
        model_task_period = TASK_PERIOD_RESET;
        err_count = 0;
        burst_left = 0;
        far_deadlines_left = 4;
        stall_cycle = 0;
        stall_mode = 0;
        stall_hold = 0;
        stall_pattern = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_tick();
        test_order_and_ties();
        test_full_queue();
        test_default_task_timer();
        test_zero_and_long_period();

        set_task_timer($urandom, 16'd1);
        test_random_traffic(18);
        set_task_timer(32'h8000_0000, 16'd3);
        test_random_traffic(18);
        set_task_timer($urandom, 16'($urandom_range(0, 4)));
        test_random_traffic(18);
        set_task_timer(TASK_VALUE_RESET, 16'hFFFF);
        test_random_traffic(18);

        wait_drained();
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("tb_timer_deadline_queue_unit: done, clean");
        end else begin
            $display("tb_timer_deadline_queue_unit: done, errors");
        end
        $finish;
    end

endmodule
